@@ sv/pfbrg_pkg.sv @@
// ----------------------------------------------------------------------------
// pfbrg_pkg
// Shared types, register indexes and helpers for the penalized FB kernel.
// ----------------------------------------------------------------------------
package pfbrg_pkg;

    typedef struct packed {
        logic signed [31:0] margin;
        logic signed [31:0] dual;
        logic signed [31:0] prior_dual;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] residual;
        logic signed [31:0] grad_first;
        logic signed [31:0] grad_scaled;
        logic signed [31:0] grad_ratio;
        logic               divide_fault;
    } t_out_item;

    // Stage enable and the valid bit that enters the first stage of a unit
    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;

    localparam int          CFG_IDX_W = 2;
    localparam int          CFG_DATA_W = 31;
    localparam logic [1:0]  CFG_BLEND = 2'd0;
    localparam logic [1:0]  CFG_PROX  = 2'd1;
    localparam logic [1:0]  CFG_RTOL  = 2'd2;

    localparam logic [16:0] BLEND_RST = 17'd62259;
    localparam logic [30:0] PROX_RST  = 31'd66;
    localparam logic [16:0] RTOL_RST  = 17'd1;
    localparam logic [16:0] ALPHA_ONE = 17'd65536;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic [47:0]        PP_CLAMP = 48'h7FFF_FFFF_FFFF;
    localparam longint             INV_SQRT2_Q30 = 64'sd759250125;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
        logic signed [31:0] res;
        if (x > 72'(S32_MAX)) begin
            res = S32_MAX;
        end else if (x < 72'(S32_MIN)) begin
            res = S32_MIN;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] x);
        logic [31:0] res;
        res = x[31] ? unsigned'(32'sd0 - x) : unsigned'(x);
        return res;
    endfunction

endpackage

@@ sv/pfbrg_sqrt.sv @@
// ----------------------------------------------------------------------------
// pfbrg_sqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module pfbrg_sqrt #(
    parameter int TW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pfbrg_pkg::t_stage_ctl i_ctl,
    input  logic [63:0]           i_rad,
    input  logic [TW-1:0]         i_tag,
    output logic                  o_valid,
    output logic [31:0]           o_root,
    output logic [TW-1:0]         o_tag
);

    localparam int NS = 32;

    logic          r_v    [NS];
    logic [31:0]   r_root [NS];
    logic [TW-1:0] r_tag  [NS];
    logic [32:0]   r_rem  [NS-1];
    logic [63:0]   r_rest [NS-1];

    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic [32:0]   p_rem;
        logic [31:0]   p_root;
        logic [63:0]   p_rest;
        logic          p_v;
        logic [TW-1:0] p_tag;
        logic [34:0]   acc;
        logic [34:0]   trial;
        logic          ge;
        logic [34:0]   n_rem;
        logic [31:0]   n_root;

        if (g == 0) begin : g_head
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rest = i_rad;
            assign p_v    = i_ctl.valid;
            assign p_tag  = i_tag;
        end else begin : g_body
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_rest = r_rest[g-1];
            assign p_v    = r_v[g-1];
            assign p_tag  = r_tag[g-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign acc    = {p_rem, p_rest[63:62]};
        assign trial  = {1'b0, p_root, 2'b01};
        assign ge     = acc >= trial;
        assign n_rem  = ge ? acc - trial : acc;
        assign n_root = {p_root[30:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[g] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_root[g] <= n_root;
                r_tag[g]  <= p_tag;
            end
        end

        if (g < NS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_rem[g]  <= n_rem[32:0];
                    r_rest[g] <= {p_rest[61:0], 2'b00};
                end
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_root  = r_root[NS-1];
    assign o_tag   = r_tag[NS-1];

endmodule

@@ sv/pfbrg_div.sv @@
// ----------------------------------------------------------------------------
// pfbrg_div
// Pipelined signed divide with saturation: magnitude in, one quotient bit
// per stage, sign and saturation applied in the last stage.
// ----------------------------------------------------------------------------
module pfbrg_div #(
    parameter int NW = 48,
    parameter int TW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pfbrg_pkg::t_stage_ctl i_ctl,
    input  logic [NW-1:0]         i_num,
    input  logic [31:0]           i_den,
    input  logic                  i_neg,
    input  logic [TW-1:0]         i_tag,
    output logic                  o_valid,
    output logic signed [31:0]    o_quo,
    output logic [TW-1:0]         o_tag
);

    localparam int NS = 32;

    typedef struct packed {
        logic neg;
        logic ovf;
        logic zero;
    } t_div_flags;

    // head stage: overflow check and initial remainder
    logic [31:0]   c_hi;
    logic          r_h_v;
    logic [31:0]   r_h_rem;
    logic [31:0]   r_h_lo;
    logic [31:0]   r_h_den;
    t_div_flags    r_h_fl;
    logic [TW-1:0] r_h_tag;

    assign c_hi = {{(64-NW){1'b0}}, i_num[NW-1:32]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else if (i_ctl.en) begin
            r_h_v <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_h_rem     <= c_hi;
            r_h_lo      <= i_num[31:0];
            r_h_den     <= i_den;
            r_h_fl.neg  <= i_neg;
            r_h_fl.ovf  <= c_hi >= i_den;
            r_h_fl.zero <= i_num == '0;
            r_h_tag     <= i_tag;
        end
    end

    logic          r_v   [NS];
    logic [31:0]   r_q   [NS];
    t_div_flags    r_fl  [NS];
    logic [TW-1:0] r_tag [NS];
    logic [31:0]   r_rem [NS-1];
    logic [31:0]   r_lo  [NS-1];
    logic [31:0]   r_den [NS-1];

    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic [31:0]   p_rem;
        logic [31:0]   p_lo;
        logic [31:0]   p_den;
        logic [31:0]   p_q;
        t_div_flags    p_fl;
        logic          p_v;
        logic [TW-1:0] p_tag;
        logic [32:0]   acc;
        logic          ge;
        logic [32:0]   n_rem;

        if (g == 0) begin : g_head
            assign p_rem = r_h_rem;
            assign p_lo  = r_h_lo;
            assign p_den = r_h_den;
            assign p_q   = '0;
            assign p_fl  = r_h_fl;
            assign p_v   = r_h_v;
            assign p_tag = r_h_tag;
        end else begin : g_body
            assign p_rem = r_rem[g-1];
            assign p_lo  = r_lo[g-1];
            assign p_den = r_den[g-1];
            assign p_q   = r_q[g-1];
            assign p_fl  = r_fl[g-1];
            assign p_v   = r_v[g-1];
            assign p_tag = r_tag[g-1];
        end

        assign acc   = {p_rem, p_lo[31]};
        assign ge    = acc >= {1'b0, p_den};
        assign n_rem = ge ? acc - {1'b0, p_den} : acc;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[g] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_q[g]   <= {p_q[30:0], ge};
                r_fl[g]  <= p_fl;
                r_tag[g] <= p_tag;
            end
        end

        if (g < NS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_rem[g] <= n_rem[31:0];
                    r_lo[g]  <= {p_lo[30:0], 1'b0};
                    r_den[g] <= p_den;
                end
            end
        end
    end

    // sign and saturate
    logic [31:0]        c_q;
    t_div_flags         c_fl;
    logic signed [31:0] c_quo;
    logic               r_o_v;
    logic signed [31:0] r_o_quo;
    logic [TW-1:0]      r_o_tag;

    assign c_q  = r_q[NS-1];
    assign c_fl = r_fl[NS-1];

    always_comb begin
        if (c_fl.zero) begin
            c_quo = '0;
        end else if (c_fl.ovf) begin
            c_quo = c_fl.neg ? pfbrg_pkg::S32_MIN : pfbrg_pkg::S32_MAX;
        end else if (c_fl.neg) begin
            c_quo = (c_q > 32'h8000_0000) ? pfbrg_pkg::S32_MIN : signed'(32'd0 - c_q);
        end else begin
            c_quo = c_q[31] ? pfbrg_pkg::S32_MAX : signed'(c_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (i_ctl.en) begin
            r_o_v <= r_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_o_quo <= c_quo;
            r_o_tag <= r_tag[NS-1];
        end
    end

    assign o_valid = r_o_v;
    assign o_quo   = r_o_quo;
    assign o_tag   = r_o_tag;

endmodule

@@ sv/penalized_fb_residual_and_gradient_top.sv @@
// ----------------------------------------------------------------------------
// penalized_fb_residual_and_gradient_top
// Per-constraint penalized Fischer-Burmeister residual, generalized gradient
// and gradient ratio in signed fixed point.
// ----------------------------------------------------------------------------
// Pipeline: 6 front stages, 32-stage square root, 2 stages, 34-stage divide pair,
//   5 stages, 34-stage divide, output.
// Throughput: one beat per cycle; every stage is a register that advances when
//   the output register is empty or being taken.
// Reset clears all valid bits and loads the configuration registers with their
//   default values; payload registers are not reset.
module penalized_fb_residual_and_gradient_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  pfbrg_pkg::t_in_item   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pfbrg_pkg::t_out_item  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [30:0]           i_cfg_data
);

    localparam int F  = FRAC_BITS;
    localparam int NW = 32 + F;
    localparam int DSH = 30 - F;
    localparam longint DC = (DSH == 0) ? pfbrg_pkg::INV_SQRT2_Q30 :
        ((pfbrg_pkg::INV_SQRT2_Q30 + (64'sd1 <<< ((DSH > 0) ? DSH - 1 : 0))) >>> DSH);
    localparam logic signed [31:0] ONE_M_D = 32'((64'sd1 <<< F) - DC);
    localparam logic signed [33:0] ONE_F   = 34'sd1 <<< F;
    localparam logic signed [66:0] HALF_F  = 67'sd1 <<< (F - 1);
    localparam logic signed [66:0] HALF_A  = 67'sd1 <<< 15;
    localparam logic signed [52:0] HALF_A53 = 53'sd1 <<< 15;

    // ---------------- configuration ----------------
    logic [16:0] r_blend;
    logic [30:0] r_prox;
    logic [16:0] r_rtol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend <= pfbrg_pkg::BLEND_RST;
            r_prox  <= pfbrg_pkg::PROX_RST;
            r_rtol  <= pfbrg_pkg::RTOL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pfbrg_pkg::CFG_BLEND: r_blend <= i_cfg_data[16:0];
                pfbrg_pkg::CFG_PROX:  r_prox  <= i_cfg_data;
                pfbrg_pkg::CFG_RTOL:  r_rtol  <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    logic [16:0]        c_alpha;
    logic [16:0]        c_w;
    logic signed [17:0] c_alpha_s;
    logic signed [17:0] c_w_s;
    logic signed [31:0] c_sig_s;

    assign c_alpha   = (r_blend > pfbrg_pkg::ALPHA_ONE) ? pfbrg_pkg::ALPHA_ONE : r_blend;
    assign c_w       = pfbrg_pkg::ALPHA_ONE - c_alpha;
    assign c_alpha_s = signed'({1'b0, c_alpha});
    assign c_w_s     = signed'({1'b0, c_w});
    assign c_sig_s   = signed'({1'b0, r_prox});

    logic w_en;
    logic r_out_v;

    assign w_en       = !r_out_v || i_out_ready;
    assign o_in_ready = w_en;

    // ---------------- S1: sigma * (v - vbar) ----------------
    logic signed [32:0] c_diff;
    logic               r1_vld;
    logic signed [64:0] r1_prod;
    logic signed [31:0] r1_y;
    logic signed [31:0] r1_dual;

    assign c_diff = 33'(i_in_data.dual) - 33'(i_in_data.prior_dual);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_prod <= c_sig_s * c_diff;
            r1_y    <= i_in_data.margin;
            r1_dual <= i_in_data.dual;
        end
    end

    // ---------------- S2: shifted margin ----------------
    logic signed [66:0] c_ys_sum;
    logic               r2_vld;
    logic signed [31:0] r2_ys;
    logic signed [31:0] r2_dual;

    assign c_ys_sum = 67'(r1_y) + ((67'(r1_prod) + HALF_F) >>> F);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ys   <= pfbrg_pkg::sat32(72'(c_ys_sum));
            r2_dual <= r1_dual;
        end
    end

    // ---------------- S3: squares and cross product ----------------
    logic               r3_vld;
    logic signed [63:0] r3_ysq;
    logic signed [63:0] r3_vsq;
    logic signed [63:0] r3_ysv;
    logic signed [31:0] r3_ys;
    logic signed [31:0] r3_dual;
    logic               r3_bp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_ysq  <= r2_ys * r2_ys;
            r3_vsq  <= r2_dual * r2_dual;
            r3_ysv  <= r2_ys * r2_dual;
            r3_ys   <= r2_ys;
            r3_dual <= r2_dual;
            r3_bp   <= (r2_ys > 32'sd0) && (r2_dual > 32'sd0);
        end
    end

    // ---------------- S4: radicand and product penalty ----------------
    logic signed [63:0] c_ppw;
    logic               r4_vld;
    logic [63:0]        r4_sq;
    logic [47:0]        r4_pp;
    logic signed [31:0] r4_ys;
    logic signed [31:0] r4_dual;
    logic               r4_bp;

    assign c_ppw = r3_ysv >>> F;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_sq <= unsigned'(r3_ysq + r3_vsq);
            if (!r3_bp) begin
                r4_pp <= '0;
            end else if (c_ppw > signed'({16'b0, pfbrg_pkg::PP_CLAMP})) begin
                r4_pp <= pfbrg_pkg::PP_CLAMP;
            end else begin
                r4_pp <= c_ppw[47:0];
            end
            r4_ys   <= r3_ys;
            r4_dual <= r3_dual;
            r4_bp   <= r3_bp;
        end
    end

    // ---------------- S5/S6: (1-alpha) * penalty in two halves ----------------
    logic               r5_vld;
    logic [40:0]        r5_wlo;
    logic [40:0]        r5_whi;
    logic [63:0]        r5_sq;
    logic signed [31:0] r5_ys;
    logic signed [31:0] r5_dual;
    logic               r5_bp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_wlo  <= c_w * r4_pp[23:0];
            r5_whi  <= c_w * r4_pp[47:24];
            r5_sq   <= r4_sq;
            r5_ys   <= r4_ys;
            r5_dual <= r4_dual;
            r5_bp   <= r4_bp;
        end
    end

    logic               r6_vld;
    logic [64:0]        r6_wp;
    logic [63:0]        r6_sq;
    logic signed [31:0] r6_ys;
    logic signed [31:0] r6_dual;
    logic               r6_bp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (w_en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_wp   <= {r5_whi, 24'b0} + 65'(r5_wlo);
            r6_sq   <= r5_sq;
            r6_ys   <= r5_ys;
            r6_dual <= r5_dual;
            r6_bp   <= r5_bp;
        end
    end

    // ---------------- square root ----------------
    typedef struct packed {
        logic signed [31:0] ys;
        logic signed [31:0] dual;
        logic               bp;
        logic [64:0]        wp;
    } t_sq_tag;

    pfbrg_pkg::t_stage_ctl w_ctl_sq;
    t_sq_tag               w_sq_tag_in;
    logic [$bits(t_sq_tag)-1:0] w_sq_tag_out;
    t_sq_tag               w_sq_tag;
    logic                  w_sq_vld;
    logic [31:0]           w_root;

    assign w_ctl_sq.en    = w_en;
    assign w_ctl_sq.valid = r6_vld;
    assign w_sq_tag_in.ys   = r6_ys;
    assign w_sq_tag_in.dual = r6_dual;
    assign w_sq_tag_in.bp   = r6_bp;
    assign w_sq_tag_in.wp   = r6_wp;
    assign w_sq_tag = t_sq_tag'(w_sq_tag_out);

    pfbrg_sqrt #(
        .TW ($bits(t_sq_tag))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_sq),
        .i_rad   (r6_sq),
        .i_tag   (w_sq_tag_in),
        .o_valid (w_sq_vld),
        .o_root  (w_root),
        .o_tag   (w_sq_tag_out)
    );

    // ---------------- S7: radius, FB term ----------------
    logic signed [31:0] c_r;
    logic               c_near;
    logic signed [33:0] c_fb;
    logic               r7_vld;
    logic signed [51:0] r7_af;
    logic [64:0]        r7_wp;
    logic signed [31:0] r7_r;
    logic signed [31:0] r7_ys;
    logic signed [31:0] r7_dual;
    logic               r7_bp;
    logic               r7_near;

    assign c_r    = w_root[31] ? pfbrg_pkg::S32_MAX : signed'(w_root);
    assign c_near = {15'b0, r_rtol} > unsigned'(c_r);
    assign c_fb   = 34'(w_sq_tag.ys) + 34'(w_sq_tag.dual) - 34'(c_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (w_en) begin
            r7_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_af   <= c_alpha_s * c_fb;
            r7_wp   <= w_sq_tag.wp;
            r7_r    <= c_r;
            r7_ys   <= w_sq_tag.ys;
            r7_dual <= w_sq_tag.dual;
            r7_bp   <= w_sq_tag.bp;
            r7_near <= c_near;
        end
    end

    // ---------------- S8: residual, divider operands ----------------
    logic signed [66:0] c_rsum;
    logic signed [66:0] c_rsh;
    logic               r8_vld;
    logic signed [31:0] r8_resid;
    logic [NW-1:0]      r8_numa;
    logic [NW-1:0]      r8_numb;
    logic               r8_nega;
    logic               r8_negb;
    logic [31:0]        r8_den;
    logic signed [31:0] r8_ys;
    logic signed [31:0] r8_dual;
    logic               r8_bp;
    logic               r8_near;

    assign c_rsum = 67'(r7_af) + signed'({2'b0, r7_wp});
    assign c_rsh  = (c_rsum + HALF_A) >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (w_en) begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_resid <= pfbrg_pkg::sat32(72'(c_rsh));
            r8_numa  <= {pfbrg_pkg::abs32(r7_ys), {F{1'b0}}};
            r8_numb  <= {pfbrg_pkg::abs32(r7_dual), {F{1'b0}}};
            r8_nega  <= r7_ys[31];
            r8_negb  <= r7_dual[31];
            r8_den   <= unsigned'(r7_r);
            r8_ys    <= r7_ys;
            r8_dual  <= r7_dual;
            r8_bp    <= r7_bp;
            r8_near  <= r7_near;
        end
    end

    // ---------------- ys/r and v/r ----------------
    typedef struct packed {
        logic signed [31:0] resid;
        logic signed [31:0] ys;
        logic signed [31:0] dual;
    } t_da_tag;

    typedef struct packed {
        logic near;
        logic bp;
    } t_db_tag;

    pfbrg_pkg::t_stage_ctl w_ctl_d;
    t_da_tag               w_da_in;
    t_db_tag               w_db_in;
    logic [$bits(t_da_tag)-1:0] w_da_out;
    logic [$bits(t_db_tag)-1:0] w_db_out;
    t_da_tag               w_da;
    t_db_tag               w_db;
    logic                  w_qa_valid;
    logic                  w_qb_valid;
    logic signed [31:0]    w_qa;
    logic signed [31:0]    w_qb;

    assign w_ctl_d.en    = w_en;
    assign w_ctl_d.valid = r8_vld;
    assign w_da_in.resid = r8_resid;
    assign w_da_in.ys    = r8_ys;
    assign w_da_in.dual  = r8_dual;
    assign w_db_in.near  = r8_near;
    assign w_db_in.bp    = r8_bp;
    assign w_da = t_da_tag'(w_da_out);
    assign w_db = t_db_tag'(w_db_out);

    pfbrg_div #(
        .NW (NW),
        .TW ($bits(t_da_tag))
    ) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_d),
        .i_num   (r8_numa),
        .i_den   (r8_den),
        .i_neg   (r8_nega),
        .i_tag   (w_da_in),
        .o_valid (w_qa_valid),
        .o_quo   (w_qa),
        .o_tag   (w_da_out)
    );

    pfbrg_div #(
        .NW (NW),
        .TW ($bits(t_db_tag))
    ) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_d),
        .i_num   (r8_numb),
        .i_den   (r8_den),
        .i_neg   (r8_negb),
        .i_tag   (w_db_in),
        .o_valid (w_qb_valid),
        .o_quo   (w_qb),
        .o_tag   (w_db_out)
    );

    // ---------------- S9: gradient products ----------------
    logic signed [33:0] c_oma;
    logic signed [33:0] c_omb;
    logic               r9_vld;
    logic signed [51:0] r9_ax;
    logic signed [51:0] r9_ay;
    logic signed [49:0] r9_wx;
    logic signed [49:0] r9_wy;
    logic signed [49:0] r9_kn;
    logic               r9_near;
    logic signed [31:0] r9_resid;

    assign c_oma = ONE_F - 34'(w_qa);
    assign c_omb = ONE_F - 34'(w_qb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else if (w_en) begin
            r9_vld <= w_qa_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_ax    <= c_alpha_s * c_oma;
            r9_ay    <= c_alpha_s * c_omb;
            r9_wx    <= w_db.bp ? c_w_s * w_da.dual : '0;
            r9_wy    <= w_db.bp ? c_w_s * w_da.ys : '0;
            r9_kn    <= c_alpha_s * ONE_M_D;
            r9_near  <= w_db.near;
            r9_resid <= w_da.resid;
        end
    end

    // ---------------- S10: gamma and dv ----------------
    logic signed [52:0] c_tx;
    logic signed [52:0] c_ty;
    logic signed [31:0] c_gk;
    logic               r10_vld;
    logic signed [31:0] r10_gx;
    logic signed [31:0] r10_gy;
    logic signed [31:0] r10_resid;

    assign c_tx = 53'(r9_ax) + 53'(r9_wx);
    assign c_ty = 53'(r9_ay) + 53'(r9_wy);
    assign c_gk = pfbrg_pkg::sat32(72'((53'(r9_kn) + HALF_A53) >>> 16));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else if (w_en) begin
            r10_vld <= r9_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_gx <= r9_near ? c_gk : pfbrg_pkg::sat32(72'((c_tx + HALF_A53) >>> 16));
            r10_gy <= r9_near ? c_gk : pfbrg_pkg::sat32(72'((c_ty + HALF_A53) >>> 16));
            r10_resid <= r9_resid;
        end
    end

    // ---------------- S11/S12: mu ----------------
    logic               r11_vld;
    logic signed [63:0] r11_sg;
    logic signed [31:0] r11_gx;
    logic signed [31:0] r11_gy;
    logic signed [31:0] r11_resid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_vld <= 1'b0;
        end else if (w_en) begin
            r11_vld <= r10_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r11_sg    <= c_sig_s * r10_gx;
            r11_gx    <= r10_gx;
            r11_gy    <= r10_gy;
            r11_resid <= r10_resid;
        end
    end

    logic signed [66:0] c_mus;
    logic               r12_vld;
    logic signed [31:0] r12_mu;
    logic signed [31:0] r12_gx;
    logic signed [31:0] r12_resid;

    assign c_mus = 67'(r11_gy) + ((67'(r11_sg) + HALF_F) >>> F);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_vld <= 1'b0;
        end else if (w_en) begin
            r12_vld <= r11_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r12_mu    <= pfbrg_pkg::sat32(72'(c_mus));
            r12_gx    <= r11_gx;
            r12_resid <= r11_resid;
        end
    end

    // ---------------- S13: ratio operands ----------------
    typedef struct packed {
        logic signed [31:0] resid;
        logic signed [31:0] gx;
        logic signed [31:0] mu;
        logic               fault;
    } t_dc_tag;

    logic               r13_vld;
    logic [NW-1:0]      r13_num;
    logic [31:0]        r13_den;
    logic               r13_neg;
    t_dc_tag            r13_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r13_vld <= 1'b0;
        end else if (w_en) begin
            r13_vld <= r12_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r13_num       <= {pfbrg_pkg::abs32(r12_gx), {F{1'b0}}};
            r13_den       <= pfbrg_pkg::abs32(r12_mu);
            r13_neg       <= r12_gx[31] ^ r12_mu[31];
            r13_tag.resid <= r12_resid;
            r13_tag.gx    <= r12_gx;
            r13_tag.mu    <= r12_mu;
            r13_tag.fault <= r12_mu == 32'sd0;
        end
    end

    pfbrg_pkg::t_stage_ctl w_ctl_c;
    logic [$bits(t_dc_tag)-1:0] w_dc_out;
    t_dc_tag               w_dc;
    logic                  w_dc_vld;
    logic signed [31:0]    w_ratio;

    assign w_ctl_c.en    = w_en;
    assign w_ctl_c.valid = r13_vld;
    assign w_dc = t_dc_tag'(w_dc_out);

    pfbrg_div #(
        .NW (NW),
        .TW ($bits(t_dc_tag))
    ) u_div_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_c),
        .i_num   (r13_num),
        .i_den   (r13_den),
        .i_neg   (r13_neg),
        .i_tag   (r13_tag),
        .o_valid (w_dc_vld),
        .o_quo   (w_ratio),
        .o_tag   (w_dc_out)
    );

    // ---------------- output register ----------------
    pfbrg_pkg::t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_dc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.residual    <= w_dc.resid;
            r_out.grad_first  <= w_dc.gx;
            r_out.grad_scaled <= w_dc.mu;
            // zero mu: pin the ratio to the rail on the side of gamma
            r_out.grad_ratio  <= !w_dc.fault ? w_ratio :
                                 (w_dc.gx[31] ? pfbrg_pkg::S32_MIN : pfbrg_pkg::S32_MAX);
            r_out.divide_fault <= w_dc.fault;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // ---------------- assertions ----------------
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qa_valid == w_qb_valid)
        else $error("divider lanes out of step");

    a_fault_mu_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.divide_fault |-> o_out_data.grad_scaled == 32'sd0)
        else $error("divide fault without zero mu");

    a_fault_ratio_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.divide_fault |->
            (o_out_data.grad_ratio == pfbrg_pkg::S32_MAX ||
             o_out_data.grad_ratio == pfbrg_pkg::S32_MIN))
        else $error("faulted ratio not on a rail");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the penalized Fischer-Burmeister kernel: a directed
// table and random streams under several register settings, with every output
// beat checked field by field against the table or an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        pfbrg_pkg::t_in_item  stim;
        bit                   typed;
        pfbrg_pkg::t_out_item want;
    } t_row;

    localparam int DRAIN_CYCLES = 140;
    localparam int PHASE_ITEMS  = 225;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    pfbrg_pkg::t_in_item  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    pfbrg_pkg::t_out_item o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic [1:0]           i_cfg_idx = pfbrg_pkg::CFG_BLEND;
    logic [30:0]          i_cfg_data = '0;

    // predictor copy of the registers
    logic [16:0] blend_q = pfbrg_pkg::BLEND_RST;
    logic [30:0] prox_q  = pfbrg_pkg::PROX_RST;
    logic [16:0] rtol_q  = pfbrg_pkg::RTOL_RST;

    pfbrg_pkg::t_out_item pending_q[$];
    int        error_cnt = 0;
    int        in_beats = 0;
    bit        quiet = 0;
    bit        long_hold_done = 0;
    int        hold_cnt = 0;

    penalized_fb_residual_and_gradient_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_wide round_half_up(t_wide x, int s);
        return (x + (t_wide'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic t_wide clamp_s32(t_wide x);
        t_wide hi, lo;
        hi = t_wide'(pfbrg_pkg::S32_MAX);
        lo = t_wide'(pfbrg_pkg::S32_MIN);
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    function automatic t_wide quot_sat(t_wide num, t_wide den);
        if (den == 0) begin
            if (num == 0) return 0;
            return (num > 0) ? t_wide'(pfbrg_pkg::S32_MAX) : t_wide'(pfbrg_pkg::S32_MIN);
        end
        return clamp_s32(num / den);
    endfunction

    function automatic logic [63:0] sqrt_floor(logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Penalized FB residual, generalized gradient, mu and gamma/mu for one beat
    function automatic pfbrg_pkg::t_out_item fb_kernel(pfbrg_pkg::t_in_item x);
        t_wide one, dconst, alpha, w, sigma, tol, y, v, vbar;
        t_wide ys, sq, r, fb, pp, resid, gx, gy, mu, qa, qb, tx, ty, ratio;
        pfbrg_pkg::t_out_item o;
        one    = 65536;
        dconst = round_half_up(t_wide'(pfbrg_pkg::INV_SQRT2_Q30), 14);
        alpha  = blend_q;
        if (alpha > 65536) alpha = 65536;
        w      = 65536 - alpha;
        sigma  = prox_q;
        tol    = rtol_q;
        y      = x.margin;
        v      = x.dual;
        vbar   = x.prior_dual;

        ys = clamp_s32(y + round_half_up(sigma * (v - vbar), 16));
        sq = ys * ys + v * v;
        r  = sqrt_floor(sq[63:0]);
        if (r > t_wide'(pfbrg_pkg::S32_MAX)) r = t_wide'(pfbrg_pkg::S32_MAX);

        fb = ys + v - r;
        pp = 0;
        if (ys > 0 && v > 0) begin
            pp = (ys * v) >>> 16;
            if (pp > t_wide'(pfbrg_pkg::PP_CLAMP)) pp = t_wide'(pfbrg_pkg::PP_CLAMP);
        end
        resid = clamp_s32(round_half_up(alpha * fb + w * pp, 16));
        o.residual = resid[31:0];

        if (r < tol) begin
            gx = clamp_s32(round_half_up(alpha * (one - dconst), 16));
            gy = gx;
        end else begin
            qa = quot_sat(ys * one, r);
            qb = quot_sat(v * one, r);
            tx = alpha * (one - qa);
            ty = alpha * (one - qb);
            if (ys > 0 && v > 0) begin
                tx = tx + w * v;
                ty = ty + w * ys;
            end
            gx = clamp_s32(round_half_up(tx, 16));
            gy = clamp_s32(round_half_up(ty, 16));
        end

        mu = clamp_s32(gy + round_half_up(sigma * gx, 16));
        o.divide_fault = (mu == 0);
        if (mu == 0) begin
            ratio = (gx >= 0) ? t_wide'(pfbrg_pkg::S32_MAX) : t_wide'(pfbrg_pkg::S32_MIN);
        end else begin
            ratio = quot_sat(gx * one, mu);
        end

        o.grad_first  = gx[31:0];
        o.grad_scaled = mu[31:0];
        o.grad_ratio  = ratio[31:0];
        return o;
    endfunction

    function automatic logic signed [31:0] pick_edge();
        case ($urandom_range(0, 4))
            0: return pfbrg_pkg::S32_MIN;
            1: return pfbrg_pkg::S32_MAX;
            2: return 32'sd0;
            3: return 32'sd1;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic logic signed [31:0] near_zero(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic pfbrg_pkg::t_in_item random_item();
        pfbrg_pkg::t_in_item x;
        int kind;
        kind = $urandom_range(0, 9);
        x.margin = $urandom;
        x.dual = $urandom;
        x.prior_dual = $urandom;
        case (kind)
            3, 4, 5: begin
                x.margin = near_zero(1 << 19);
                x.dual = near_zero(1 << 19);
                x.prior_dual = x.dual + near_zero(1 << 12);
            end
            6: begin
                x.margin = $urandom_range(1, 1 << 22);
                x.dual = $urandom_range(1, 1 << 22);
                x.prior_dual = x.dual;
            end
            7: begin
                x.margin = near_zero(2);
                x.dual = near_zero(2);
                x.prior_dual = x.dual + near_zero(1);
            end
            8: begin
                x.margin = pick_edge();
                x.dual = pick_edge();
                x.prior_dual = pick_edge();
            end
            9: x.prior_dual = x.dual;
            default: ;
        endcase
        return x;
    endfunction

    task automatic send_beat(pfbrg_pkg::t_in_item x, bit typed, pfbrg_pkg::t_out_item want);
        i_in_valid <= 1'b1;
        i_in_data <= x;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_q.push_back(typed ? want : fb_kernel(x));
        in_beats++;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            pfbrg_pkg::CFG_BLEND: blend_q = data[16:0];
            pfbrg_pkg::CFG_PROX:  prox_q = data;
            pfbrg_pkg::CFG_RTOL:  rtol_q = data[16:0];
            default: ;
        endcase
    endtask

    // Drain the pipeline, then load all three registers
    task automatic set_regs(logic [30:0] blend, logic [30:0] prox, logic [30:0] rtol);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(pfbrg_pkg::CFG_BLEND, blend);
        write_reg(pfbrg_pkg::CFG_PROX, prox);
        write_reg(pfbrg_pkg::CFG_RTOL, rtol);
    endtask

    task automatic random_phase(int n);
        pfbrg_pkg::t_out_item none;
        none = '0;
        repeat (n) send_beat(random_item(), 1'b0, none);
    endtask

    // Receiver: random stall bursts, plus one long hold to back up the pipe
    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_ready <= 1'b0;
        end else if (!long_hold_done && in_beats >= 300) begin
            long_hold_done <= 1'b1;
            hold_cnt <= 599;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            hold_cnt <= $urandom_range(0, 16);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        pfbrg_pkg::t_out_item exp_beat;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected beat %p", $time, o_out_data);
                error_cnt++;
            end else begin
                exp_beat = pending_q.pop_front();
                if (o_out_data.residual !== exp_beat.residual) begin
                    $display("%0t: residual exp %0d got %0d", $time,
                             exp_beat.residual, o_out_data.residual);
                    error_cnt++;
                end
                if (o_out_data.grad_first !== exp_beat.grad_first) begin
                    $display("%0t: grad_first exp %0d got %0d", $time,
                             exp_beat.grad_first, o_out_data.grad_first);
                    error_cnt++;
                end
                if (o_out_data.grad_scaled !== exp_beat.grad_scaled) begin
                    $display("%0t: grad_scaled exp %0d got %0d", $time,
                             exp_beat.grad_scaled, o_out_data.grad_scaled);
                    error_cnt++;
                end
                if (o_out_data.grad_ratio !== exp_beat.grad_ratio) begin
                    $display("%0t: grad_ratio exp %0d got %0d", $time,
                             exp_beat.grad_ratio, o_out_data.grad_ratio);
                    error_cnt++;
                end
                if (o_out_data.divide_fault !== exp_beat.divide_fault) begin
                    $display("%0t: divide_fault exp %0b got %0b", $time,
                             exp_beat.divide_fault, o_out_data.divide_fault);
                    error_cnt++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_row rows[$];
        t_row row;
        pfbrg_pkg::t_out_item blank;
        blank = '0;

        // unity alpha, no proximal term, zero tolerance: results read off directly
        row.typed = 1'b1;
        row.stim = '{32'sd0, 32'sd0, 32'sd0};
        row.want = '{32'sd0, 32'sd65536, 32'sd65536, 32'sd65536, 1'b0};
        rows.push_back(row);
        row.stim = '{32'sd65536, 32'sd0, 32'sd0};
        row.want = '{32'sd0, 32'sd0, 32'sd65536, 32'sd0, 1'b0};
        rows.push_back(row);
        // mu collapses to zero: fault with positive saturation
        row.stim = '{32'sd0, 32'sd65536, 32'sd0};
        row.want = '{32'sd0, 32'sd65536, 32'sd0, pfbrg_pkg::S32_MAX, 1'b1};
        rows.push_back(row);
        row.typed = 1'b0;
        row.want = blank;
        row.stim = '{pfbrg_pkg::S32_MAX, pfbrg_pkg::S32_MAX, pfbrg_pkg::S32_MAX};
        rows.push_back(row);
        row.stim = '{pfbrg_pkg::S32_MIN, pfbrg_pkg::S32_MIN, pfbrg_pkg::S32_MIN};
        rows.push_back(row);
        row.stim = '{pfbrg_pkg::S32_MAX, pfbrg_pkg::S32_MIN, pfbrg_pkg::S32_MAX};
        rows.push_back(row);
        row.stim = '{pfbrg_pkg::S32_MIN, pfbrg_pkg::S32_MAX, pfbrg_pkg::S32_MIN};
        rows.push_back(row);
        row.stim = '{32'sd131072, 32'sd196608, 32'sd0};  rows.push_back(row);
        row.stim = '{-32'sd65536, 32'sd65536, 32'sd0};   rows.push_back(row);
        row.stim = '{32'sd65536, -32'sd65536, 32'sd0};   rows.push_back(row);
        row.stim = '{-32'sd1, -32'sd1, 32'sd0};          rows.push_back(row);
        row.stim = '{32'sd1, 32'sd1, 32'sd1};            rows.push_back(row);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        random_phase(PHASE_ITEMS);

        set_regs(31'd65536, 31'd0, 31'd0);
        foreach (rows[k]) send_beat(rows[k].stim, rows[k].typed, rows[k].want);

        set_regs(31'd0, 31'h7FFF_FFFF, 31'd65536);
        random_phase(PHASE_ITEMS);
        set_regs(31'd131071, 31'd1, 31'd131071);
        random_phase(PHASE_ITEMS);
        set_regs(31'd65536, 31'd65536, 31'd0);
        random_phase(PHASE_ITEMS);
        set_regs(31'd32768, 31'd6554, 31'd100);
        random_phase(PHASE_ITEMS);
        set_regs(31'd1, 31'd0, 31'd1);
        random_phase(PHASE_ITEMS);
        set_regs(31'(pfbrg_pkg::BLEND_RST), 31'(pfbrg_pkg::PROX_RST), 31'(pfbrg_pkg::RTOL_RST));
        random_phase(PHASE_ITEMS);
        set_regs(31'd50000, 31'd3000, 31'd20);
        quiet = 1;
        random_phase(PHASE_ITEMS);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ penalized_fb_residual_and_gradient_top.f @@
sv/pfbrg_pkg.sv
sv/pfbrg_sqrt.sv
sv/pfbrg_div.sv
sv/penalized_fb_residual_and_gradient_top.sv
bench/tb_top.sv
